@@ src/b64enc_pkg.sv @@
package b64enc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CHAR_W   = 7;
   localparam int unsigned SEXTET_W = 6;
   localparam int unsigned GROUP_W  = 3 * BYTE_W;
   localparam int unsigned NCHAR_W  = 3;

   localparam logic [CHAR_W-1:0] PAD_CHAR = 7'h3d;

   // one full or zero-filled three-byte group on its way to the back end
   typedef struct packed {
      logic [GROUP_W-1:0] data;
      logic [NCHAR_W-1:0] nchars;
      logic               last;
   } group_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   function automatic logic [CHAR_W-1:0] sextet_to_char(input logic [SEXTET_W-1:0] s);
      logic [CHAR_W-1:0] res;
      logic [CHAR_W-1:0] sx;
      sx = {1'b0, s};
      if (s < 6'd26) begin
         res = 7'h41 + sx;
      end else if (s < 6'd52) begin
         res = 7'h61 + sx - 7'd26;
      end else if (s < 6'd62) begin
         res = 7'h30 + sx - 7'd52;
      end else if (s == 6'd62) begin
         res = 7'h2b;
      end else begin
         res = 7'h2f;
      end
      return res;
   endfunction

endpackage

@@ src/base64_stream_encoder_core.sv @@
// the byte that completes a group or ends the message writes the group into the
// group queue; its characters are then registered in the output register
// throughput: one character per unstalled cycle, four per group; bytes that
// only fill a group are taken 1 per cycle while the 2-entry group queue has room
// reset: synchronous, clears the held bytes, empties the queue and clears rsp_valid
module base64_stream_encoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [b64enc_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                          req_last_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [b64enc_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                          rsp_last_char
);

   b64enc_pkg::q_status_type q_status;
   b64enc_pkg::group_type    push_group;
   b64enc_pkg::group_type    head;
   logic                     push;
   logic                     pop;

   b64enc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_status      (q_status),
      .push          (push),
      .push_group    (push_group)
   );

   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   b64enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

@@ src/b64enc_front.sv @@
module b64enc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [b64enc_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                          req_last_byte,
   input  b64enc_pkg::q_status_type      q_status,
   output logic                          push,
   output b64enc_pkg::group_type         push_group
);

   logic [2*b64enc_pkg::BYTE_W-1:0] pend_bytes_ff, pend_bytes_in;
   logic [1:0]                      pend_cnt_ff, pend_cnt_in;
   logic                            accept;
   logic [b64enc_pkg::BYTE_W-1:0]   h0;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign h0        = pend_bytes_ff[2*b64enc_pkg::BYTE_W-1:b64enc_pkg::BYTE_W];

   always_comb begin
      push          = 1'b0;
      push_group    = '0;
      pend_bytes_in = pend_bytes_ff;
      pend_cnt_in   = pend_cnt_ff;
      if (accept) begin
         if (pend_cnt_ff == 2'd2) begin
            push              = 1'b1;
            push_group.data   = {pend_bytes_ff, req_data_byte};
            push_group.nchars = 3'd4;
            push_group.last   = req_last_byte;
            pend_bytes_in     = '0;
            pend_cnt_in       = 2'd0;
         end else if (req_last_byte) begin
            push            = 1'b1;
            push_group.last = 1'b1;
            if (pend_cnt_ff == 2'd0) begin
               push_group.data   = {req_data_byte, 16'h0000};
               push_group.nchars = 3'd2;
            end else begin
               push_group.data   = {h0, req_data_byte, 8'h00};
               push_group.nchars = 3'd3;
            end
            pend_bytes_in = '0;
            pend_cnt_in   = 2'd0;
         end else begin
            if (pend_cnt_ff == 2'd0) begin
               pend_bytes_in = {req_data_byte, 8'h00};
            end else begin
               pend_bytes_in = {h0, req_data_byte};
            end
            pend_cnt_in = pend_cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bytes_ff <= '0;
         pend_cnt_ff   <= 2'd0;
      end else begin
         pend_bytes_ff <= pend_bytes_in;
         pend_cnt_ff   <= pend_cnt_in;
      end
   end

endmodule

@@ src/b64enc_queue.sv @@
module b64enc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  b64enc_pkg::group_type    push_group,
   input  logic                     pop,
   output b64enc_pkg::group_type    head,
   output b64enc_pkg::q_status_type q_status
);

   b64enc_pkg::group_type entry_ff [2];
   logic                  wr_ptr_ff, rd_ptr_ff;
   logic [1:0]            count_ff, count_in;

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == 2'd0);
   assign q_status.full  = (count_ff == 2'd2);

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && q_status.full) |-> pop)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

endmodule

@@ src/b64enc_back.sv @@
module b64enc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  b64enc_pkg::group_type         head,
   input  b64enc_pkg::q_status_type      q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [b64enc_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                          rsp_last_char
);

   logic [1:0]                          idx_ff;
   logic                                rsp_valid_ff;
   logic [b64enc_pkg::CHAR_W-1:0]       char_ff, char_in;
   logic                                last_ff, last_in;
   logic                                load;
   logic [b64enc_pkg::SEXTET_W-1:0]     sextet;

   // output register takes a new character when a group is queued and the register is empty or being drained
   assign load = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && (idx_ff == 2'd3);

   always_comb begin
      unique case (idx_ff)
         2'd0:    sextet = head.data[23:18];
         2'd1:    sextet = head.data[17:12];
         2'd2:    sextet = head.data[11:6];
         default: sextet = head.data[5:0];
      endcase
      if ({1'b0, idx_ff} < head.nchars) begin
         char_in = b64enc_pkg::sextet_to_char(sextet);
      end else begin
         char_in = b64enc_pkg::PAD_CHAR;
      end
      last_in = (idx_ff == 2'd3) && head.last;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= char_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= idx_ff + 2'd1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = char_ff;
   assign rsp_last_char = last_ff;

endmodule

@@ bench/b64_char_checker.sv @@
module b64_char_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [b64enc_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                          req_last_byte,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [b64enc_pkg::CHAR_W-1:0] rsp_out_char,
   input  logic                          rsp_last_char,
   output int                            error_count,
   output int                            chars_in_flight
);

   typedef struct packed {
      logic [b64enc_pkg::CHAR_W-1:0] code;
      logic                          last;
   } enc_char_type;

   localparam logic [64*8-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   enc_char_type    expected_chars[$];
   logic [15:0]     held_bytes = '0;
   logic [1:0]      held_count = '0;
   int              mismatches = 0;

   function automatic logic [b64enc_pkg::CHAR_W-1:0] base64_symbol(input logic [5:0] idx);
      logic [7:0] ascii;
      // first character of the literal sits in the top byte
      ascii = ALPHABET[(63 - int'(idx)) * 8 +: 8];
      return ascii[b64enc_pkg::CHAR_W-1:0];
   endfunction

   task automatic queue_group(input logic [23:0] group, input int nchars,
                              input logic last);
      enc_char_type c;
      for (int k = 0; k < 4; k++) begin
         c.code = (k < nchars) ? base64_symbol(group[23 - 6*k -: 6])
                               : b64enc_pkg::PAD_CHAR;
         c.last = (k == 3) ? last : 1'b0;
         expected_chars.insert(expected_chars.size(), c);
      end
   endtask

   task automatic encode_byte(input logic [b64enc_pkg::BYTE_W-1:0] b, input logic last);
      if (held_count == 2'd2) begin
         queue_group({held_bytes, b}, 4, last);
         held_bytes = '0;
         held_count = '0;
      end else if (last) begin
         // partial group: zero fill, then pad with '=' up to four
         if (held_count == 2'd0) begin
            queue_group({b, 16'h0000}, 2, 1'b1);
         end else begin
            queue_group({held_bytes[15:8], b, 8'h00}, 3, 1'b1);
         end
         held_bytes = '0;
         held_count = '0;
      end else begin
         if (held_count == 2'd0) begin
            held_bytes = {b, 8'h00};
         end else begin
            held_bytes = {held_bytes[15:8], b};
         end
         held_count = held_count + 2'd1;
      end
   endtask

   always @(posedge clock) begin
      enc_char_type want;
      if (reset) begin
         expected_chars.delete();
         held_bytes = '0;
         held_count = '0;
      end else begin
         if (req_valid && !req_stall) begin
            encode_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected transfer: char %h last %b",
                           rsp_out_char, rsp_last_char);
               end
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.code || rsp_last_char !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: char exp %h got %h, last exp %b got %b",
                              want.code, rsp_out_char, want.last, rsp_last_char);
                  end
               end
            end
         end
      end
      error_count     <= mismatches;
      chars_in_flight <= expected_chars.size();
   end

endmodule

@@ bench/testbench.sv @@
module testbench;

   localparam int ITEM_TARGET = 110;
   localparam int CYCLE_LIMIT = 60000;

   logic                          clock;
   logic                          reset         = 1'b1;
   logic                          req_valid     = 1'b0;
   logic                          req_stall;
   logic [b64enc_pkg::BYTE_W-1:0] req_data_byte = '0;
   logic                          req_last_byte = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [b64enc_pkg::CHAR_W-1:0] rsp_out_char;
   logic                          rsp_last_char;

   logic rx_stall = 1'b0;
   logic hold_off = 1'b0;
   assign rsp_stall = rx_stall | hold_off;

   int error_count;
   int chars_in_flight;
   int bytes_sent  = 0;
   int cycle_count = 0;
   bit tx_eager    = 1'b0;

   base64_stream_encoder_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   b64_char_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last_byte   (req_last_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_char   (rsp_last_char),
      .error_count     (error_count),
      .chars_in_flight (chars_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // called at a clock edge; returns at the edge of the transfer
   task automatic send_byte(input logic [b64enc_pkg::BYTE_W-1:0] b, input logic last);
      int gap;
      if (bytes_sent % 16 == 0) begin
         tx_eager = ($urandom_range(0, 3) == 0);
      end
      gap = tx_eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!(req_valid && !req_stall));
      bytes_sent++;
   endtask

   initial begin : receiver
      int hold;
      int taken;
      bit rx_eager;
      taken    = 0;
      rx_eager = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (taken % 16 == 0) begin
            rx_eager = ($urandom_range(0, 3) == 0);
         end
         hold = rx_eager ? 0 : $urandom_range(0, 7);
         if (hold > 0) begin
            rx_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rx_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   // long receiver hold-off while the sender keeps offering bytes
   initial begin : backpressure
      wait (bytes_sent >= 40);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (80) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : stimulus
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one-byte messages, both pads
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      // two-byte message, single pad
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      // full group ending the message
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      // full group mid-message, then a lone last byte
      send_byte(8'hfb, 1'b0);
      send_byte(8'hef, 1'b0);
      send_byte(8'hbe, 1'b0);
      send_byte(8'h80, 1'b1);
      // group then two-byte tail
      send_byte(8'h4d, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6e, 1'b0);
      send_byte(8'h4d, 1'b0);
      send_byte(8'h61, 1'b1);
      // walks across the upper- and lower-case ranges of the alphabet
      send_byte(8'h00, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h83, 1'b0);
      send_byte(8'h69, 1'b0);
      send_byte(8'hb6, 1'b0);
      send_byte(8'hdf, 1'b1);

      while (bytes_sent < ITEM_TARGET) begin
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
         if (len > ITEM_TARGET - bytes_sent) begin
            len = ITEM_TARGET - bytes_sent;
         end
         for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), (i == len - 1));
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (chars_in_flight != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && chars_in_flight == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
